[sv/cbd_pkg.sv]
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbd_pkg;

  // Width of the chunk size accumulator and remaining count
  localparam int SIZE_BITS  = 32;
  localparam int MaxDigits  = SIZE_BITS / 4;
  localparam int DigitW     = $clog2(MaxDigits + 1);
  localparam int LeftW      = 32;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Input operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [1:0] TRAILER_BYTES = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Classified input item passed from front to back
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cbd_item_t;

endpackage

`default_nettype wire

[sv/cbd_front.sv]
// Front end: classifies each accepted byte (hex digit, CR, LF, restart).
// Depends on cbd_pkg.
`default_nettype none

module cbd_front
  import cbd_pkg::*;
(
  input  wire logic       op,
  input  wire logic [7:0] data_byte,
  output cbd_item_t       item
);

  // Hex digit, CR, LF and restart decode
  always_comb begin
    item.restart = (op == OP_RESTART);
    item.data    = data_byte;
    item.is_cr   = (data_byte == CHAR_CR);
    item.is_lf   = (data_byte == CHAR_LF);
    item.is_hex  = 1'b0;
    item.hex_val = 4'd0;
    if (data_byte >= "0" && data_byte <= "9") begin
      item.is_hex  = 1'b1;
      item.hex_val = 4'(data_byte - "0");
    end else if (data_byte >= "a" && data_byte <= "f") begin
      item.is_hex  = 1'b1;
      item.hex_val = 4'(data_byte - "a" + 8'd10);
    end else if (data_byte >= "A" && data_byte <= "F") begin
      item.is_hex  = 1'b1;
      item.hex_val = 4'(data_byte - "A" + 8'd10);
    end
  end

endmodule

`default_nettype wire

[sv/cbd_queue.sv]
// Short queue of classified items between front and back.
// Depends on cbd_pkg.
`default_nettype none

module cbd_queue
  import cbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire cbd_item_t wr_item,
  output logic           full,
  input  wire logic      rd_en,
  output cbd_item_t      rd_item,
  output logic           has_item
);

  cbd_item_t        mem [QueueDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QueueDepth));
  assign has_item = (count != '0);
  assign rd_item  = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + QPtrW'(1);
      if (rd_en) rptr <= rptr + QPtrW'(1);
      if (wr_en && !rd_en) begin
        count <= count + QCntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/cbd_back.sv]
// Back end: chunk parsing state machine with a one-entry result register.
// Depends on cbd_pkg.
`default_nettype none

module cbd_back
  import cbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        has_item,
  input  wire cbd_item_t   item,
  output logic             take,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [LeftW-1:0] bytes_left
);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next;
  logic [DigitW-1:0]     digit_cnt, digit_cnt_next;
  logic                  past_digits, past_digits_next;
  logic                  saw_cr, saw_cr_next;
  logic [SIZE_BITS-1:0]  remaining, remaining_next;
  logic [1:0]            skip_cnt, skip_cnt_next;
  logic                  emit;
  kind_t                 emit_kind;
  logic [7:0]            emit_byte;
  logic [LeftW-1:0]      emit_left;
  logic                  out_valid;
  kind_t                 out_kind;
  logic [SIZE_BITS-1:0]  rem_dec;
  logic [1:0]            skip_dec;

  // Take an item when the result register is free or being drained
  assign take         = has_item && (!out_valid || pop);
  assign empty        = !out_valid;
  assign kind         = out_kind;
  assign rem_dec      = remaining - SIZE_BITS'(1);
  assign skip_dec     = (skip_cnt != 2'd0) ? skip_cnt - 2'd1 : 2'd0;

  // Next-state and result decode
  always_comb begin
    phase_next       = phase;
    size_accum_next  = size_accum;
    digit_cnt_next   = digit_cnt;
    past_digits_next = past_digits;
    saw_cr_next      = saw_cr;
    remaining_next   = remaining;
    skip_cnt_next    = skip_cnt;
    emit             = 1'b0;
    emit_kind        = KIND_PAYLOAD;
    emit_byte        = 8'd0;
    emit_left        = '0;
    if (item.restart) begin
      phase_next       = PH_SIZE;
      size_accum_next  = '0;
      digit_cnt_next   = '0;
      past_digits_next = 1'b0;
      saw_cr_next      = 1'b0;
      remaining_next   = '0;
      skip_cnt_next    = 2'd0;
    end else begin
      unique case (phase)
        PH_SIZE: begin
          if (saw_cr && item.is_lf) begin
            if (size_accum == '0) begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              emit_kind  = KIND_END;
            end else begin
              remaining_next = size_accum;
              phase_next     = PH_DATA;
            end
          end else begin
            saw_cr_next = item.is_cr;
            if (!past_digits && item.is_hex) begin
              if (digit_cnt >= DigitW'(MaxDigits)) begin
                phase_next = PH_ERROR;
                emit       = 1'b1;
                emit_kind  = KIND_ERROR;
              end else begin
                size_accum_next = {size_accum[SIZE_BITS-5:0], item.hex_val};
                digit_cnt_next  = digit_cnt + DigitW'(1);
              end
            end else begin
              past_digits_next = 1'b1;
            end
          end
        end
        PH_DATA: begin
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next    = PH_SKIP;
            skip_cnt_next = TRAILER_BYTES;
          end
          emit      = 1'b1;
          emit_kind = KIND_PAYLOAD;
          emit_byte = item.data;
          emit_left = LeftW'(rem_dec);
        end
        PH_SKIP: begin
          skip_cnt_next = skip_dec;
          if (skip_dec == 2'd0) begin
            phase_next       = PH_SIZE;
            size_accum_next  = '0;
            digit_cnt_next   = '0;
            past_digits_next = 1'b0;
            saw_cr_next      = 1'b0;
          end
        end
        PH_DONE, PH_ERROR: begin
        end
        default: begin
        end
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      size_accum  <= '0;
      digit_cnt   <= '0;
      past_digits <= 1'b0;
      saw_cr      <= 1'b0;
      remaining   <= '0;
      skip_cnt    <= 2'd0;
      out_valid   <= 1'b0;
      out_kind    <= KIND_PAYLOAD;
    end else begin
      if (take) begin
        phase       <= phase_next;
        size_accum  <= size_accum_next;
        digit_cnt   <= digit_cnt_next;
        past_digits <= past_digits_next;
        saw_cr      <= saw_cr_next;
        remaining   <= remaining_next;
        skip_cnt    <= skip_cnt_next;
      end
      // A new result replaces the one being popped
      if (take && emit) begin
        out_valid    <= 1'b1;
        out_kind     <= emit_kind;
        payload_byte <= emit_byte;
        bytes_left   <= emit_left;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/chunked_body_decoder.sv]
// HTTP chunked body decoder top level: front classifier, item queue, back FSM.
// Depends on cbd_pkg, cbd_front, cbd_queue, cbd_back.
//
// Usage:
//   Input side is a queue write port: drive op/data_byte and raise push;
//   the item is taken on a clock edge where push is high and full is low.
//   op 0 carries one body byte, op 1 restarts parsing for a new body.
//   Result side is a queue read port: while empty is low, kind,
//   payload_byte and bytes_left show the oldest result; pop takes it.
//   Size-line bytes give no result but end on a zero size, error on a ninth
//   digit. Nor do the two bytes after chunk data or bytes after end or error.
// Timing:
//   One item per cycle sustained while the FSM is not held by a waiting
//   result. An item's result is registered after the queue write on the
//   accepting edge and the state machine step into the result register.
//   A four-entry queue sits between classifier and FSM.
// Stalls:
//   While a result waits, the FSM holds and later items collect in the
//   queue; full rises once four are waiting. Nothing is dropped.
// Reset:
//   rst (synchronous) empties the queue and result register and returns
//   the parser to the start of a size line.
`default_nettype none

module chunked_body_decoder
  import cbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [LeftW-1:0] bytes_left
);

  cbd_item_t front_item;
  cbd_item_t head_item;
  logic      q_has_item;
  logic      back_take;
  logic      push_ok;

  assign push_ok = push && !full;

  cbd_front u_front (
    .op        (op),
    .data_byte (data_byte),
    .item      (front_item)
  );

  cbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push_ok),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (back_take),
    .rd_item  (head_item),
    .has_item (q_has_item)
  );

  cbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .has_item     (q_has_item),
    .item         (head_item),
    .take         (back_take),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .payload_byte (payload_byte),
    .bytes_left   (bytes_left)
  );

endmodule

`default_nettype wire
